>>> hw/rtl/lsmt_pkg.sv
`timescale 1ns / 1ps

package lsmt_pkg;

  // Display mode codes
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_DISPLAY_ENABLE    = 3'd0;
  localparam logic [2:0] REG_LINE_COMPARE      = 3'd1;
  localparam logic [2:0] REG_HBLANK_IRQ_ENABLE = 3'd2;
  localparam logic [2:0] REG_VBLANK_IRQ_ENABLE = 3'd3;
  localparam logic [2:0] REG_OAM_IRQ_ENABLE    = 3'd4;
  localparam logic [2:0] REG_COINC_IRQ_ENABLE  = 3'd5;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned DOT_W       = 9;
  localparam int unsigned LINE_W      = 8;

  // Dot of the last visible line at which the frame is handed off
  localparam logic [DOT_W-1:0] FRAME_READY_DOT = 9'd200;

  // Output and input tdata widths
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 8;

  typedef struct packed {
    logic              display_enable;
    logic [LINE_W-1:0] line_compare;
    logic              hblank_irq_enable;
    logic              vblank_irq_enable;
    logic              oam_irq_enable;
    logic              coincidence_irq_enable;
  } cfg_t;

  typedef struct packed {
    logic              frame_ready;
    logic              status_irq;
    logic              vblank_irq;
    logic              coincidence;
    logic [LINE_W-1:0] current_line;
    logic [1:0]        display_mode;
  } res_t;

endpackage

>>> hw/rtl/lsmt_core.sv
`timescale 1ns / 1ps

module lsmt_core #(
  parameter int DOTS_PER_LINE    = 456,
  parameter int LINES_PER_FRAME  = 154,
  parameter int VISIBLE_LINES    = 144,
  parameter int OAM_SCAN_DOTS    = 80,
  parameter int TRANSFER_END_DOT = 248
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic              tick,
  input  lsmt_pkg::cfg_t    cfg,
  output lsmt_pkg::res_t    res
);
  import lsmt_pkg::*;

  localparam logic [DOT_W-1:0]  DPL      = DOT_W'(DOTS_PER_LINE);
  localparam logic [LINE_W-1:0] LPF      = LINE_W'(LINES_PER_FRAME);
  localparam logic [LINE_W-1:0] VIS      = LINE_W'(VISIBLE_LINES);
  localparam logic [LINE_W-1:0] LAST_VIS = LINE_W'(VISIBLE_LINES - 1);
  localparam logic [DOT_W-1:0]  OAM_END  = DOT_W'(OAM_SCAN_DOTS);
  localparam logic [DOT_W-1:0]  XFER_END = DOT_W'(TRANSFER_END_DOT);

  logic [DOT_W-1:0]  dot;
  logic [LINE_W-1:0] line;
  logic [1:0]        mode;
  logic              coinc;

  logic [DOT_W-1:0]  dot_next;
  logic [LINE_W-1:0] line_next;
  logic [1:0]        mode_next;
  logic              coinc_next;
  logic [DOT_W-1:0]  dot_inc;
  logic [LINE_W-1:0] line_inc;
  logic              advance;
  logic              vblank_irq;
  logic              status_irq;
  logic              frame_ready;

  assign advance = cfg.display_enable & tick;

  // Advance the counters and derive mode, coincidence and interrupts
  always_comb begin
    dot_inc     = dot + DOT_W'(1);
    line_inc    = line + LINE_W'(1);
    dot_next    = dot;
    line_next   = line;
    mode_next   = mode;
    coinc_next  = coinc;
    vblank_irq  = 1'b0;
    status_irq  = 1'b0;
    frame_ready = 1'b0;
    if (advance) begin
      if (dot_inc >= DPL) begin
        dot_next  = '0;
        line_next = (line_inc >= LPF) ? '0 : line_inc;
      end else begin
        dot_next = dot_inc;
      end

      if (line_next >= VIS) begin
        if (line_next == VIS && dot_next == '0) begin
          vblank_irq = 1'b1;
          if (cfg.vblank_irq_enable) status_irq = 1'b1;
        end
        mode_next = MODE_VBLANK;
      end else if (dot_next == '0) begin
        if (cfg.oam_irq_enable) status_irq = 1'b1;
        mode_next = MODE_OAM;
      end else if (dot_next == OAM_END) begin
        mode_next = MODE_XFER;
      end else if (dot_next == XFER_END) begin
        if (cfg.hblank_irq_enable) status_irq = 1'b1;
        mode_next = MODE_HBLANK;
      end

      coinc_next = (line_next == cfg.line_compare);
      if (coinc_next && cfg.coincidence_irq_enable) status_irq = 1'b1;

      frame_ready = (line_next == LAST_VIS) && (dot_next == FRAME_READY_DOT);
    end
  end

  // Commit the counters when the transaction moves to the output
  always_ff @(posedge clk) begin
    if (rst) begin
      dot   <= '0;
      line  <= '0;
      mode  <= MODE_HBLANK;
      coinc <= 1'b0;
    end else if (fire) begin
      dot   <= dot_next;
      line  <= line_next;
      mode  <= mode_next;
      coinc <= coinc_next;
    end
  end

  assign res.display_mode = mode_next;
  assign res.current_line = line_next;
  assign res.coincidence  = coinc_next;
  assign res.vblank_irq   = vblank_irq;
  assign res.status_irq   = status_irq;
  assign res.frame_ready  = frame_ready;

endmodule

>>> hw/rtl/lsmt_out_buf.sv
`timescale 1ns / 1ps

module lsmt_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lsmt_pkg::res_t push_data,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output lsmt_pkg::res_t out_data
);
  import lsmt_pkg::*;

  logic main_valid;
  logic skid_valid;
  res_t main_data;
  res_t skid_data;
  logic pop;

  assign pop       = main_valid & out_ready;
  assign room      = ~skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  // Hold valid flags; a push never lands while the skid entry is full
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      main_valid <= skid_valid | push;
      skid_valid <= 1'b0;
    end else if (push) begin
      main_valid <= 1'b1;
      skid_valid <= main_valid;
    end
  end

  // Move payload between main and skid entries
  always_ff @(posedge clk) begin
    if (pop) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      if (main_valid) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

endmodule

>>> hw/rtl/lcd_scanline_mode_timer.sv
`timescale 1ns / 1ps

// LCD scanline and mode timer. Each input transaction carries one dot tick and
// returns exactly one result transaction with the display mode, current line,
// line-compare coincidence and the vblank, status and frame-ready pulses for
// that dot. A new tick is taken every clock while the output side keeps up; the
// dot and line counters advance once per accepted tick in a single update stage
// between the input register and a two-entry output buffer, and the sustained
// rate is one tick per cycle while the output side keeps up. Configuration
// writes take effect on the next clock and belong in idle periods. A tick with
// display_enable low, or with a zero tick bit, holds all counters and returns
// the held state with the pulses cleared.
module lcd_scanline_mode_timer #(
  parameter int DOTS_PER_LINE    = 456,
  parameter int LINES_PER_FRAME  = 154,
  parameter int VISIBLE_LINES    = 144,
  parameter int OAM_SCAN_DOTS    = 80,
  parameter int TRANSFER_END_DOT = 248
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [lsmt_pkg::IN_DATA_W-1:0]       s_tdata,   // [0] tick
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [1:0] display_mode, [9:2] current_line, [10] coincidence,
  // [11] vblank_irq, [12] status_irq, [13] frame_ready
  output logic [lsmt_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  logic                                 cfg_we,
  input  logic [lsmt_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lsmt_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lsmt_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_res;
  logic in_valid;
  logic in_tick;
  logic room;
  logic fire;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.display_enable         <= 1'b1;
      cfg.line_compare           <= '0;
      cfg.hblank_irq_enable      <= 1'b0;
      cfg.vblank_irq_enable      <= 1'b0;
      cfg.oam_irq_enable         <= 1'b0;
      cfg.coincidence_irq_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DISPLAY_ENABLE:    cfg.display_enable         <= cfg_data[0];
        REG_LINE_COMPARE:      cfg.line_compare           <= cfg_data[LINE_W-1:0];
        REG_HBLANK_IRQ_ENABLE: cfg.hblank_irq_enable      <= cfg_data[0];
        REG_VBLANK_IRQ_ENABLE: cfg.vblank_irq_enable      <= cfg_data[0];
        REG_OAM_IRQ_ENABLE:    cfg.oam_irq_enable         <= cfg_data[0];
        REG_COINC_IRQ_ENABLE:  cfg.coincidence_irq_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register: take a new tick whenever the stage is empty or moving on
  assign fire     = in_valid & room;
  assign s_tready = ~in_valid | room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_tick <= s_tdata[0];
    end
  end

  lsmt_core #(
    .DOTS_PER_LINE   (DOTS_PER_LINE),
    .LINES_PER_FRAME (LINES_PER_FRAME),
    .VISIBLE_LINES   (VISIBLE_LINES),
    .OAM_SCAN_DOTS   (OAM_SCAN_DOTS),
    .TRANSFER_END_DOT(TRANSFER_END_DOT)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .tick (in_tick),
    .cfg  (cfg),
    .res  (res)
  );

  lsmt_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (fire),
    .push_data(res),
    .room     (room),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (out_res)
  );

  // Pack result fields, lowest first, zero padded
  assign m_tdata = {2'b00, out_res.frame_ready, out_res.status_irq, out_res.vblank_irq,
                    out_res.coincidence, out_res.current_line, out_res.display_mode};

endmodule

>>> hw/rtl/lsmt_checker.sv
`timescale 1ns / 1ps

module lsmt_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [lsmt_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import lsmt_pkg::*;

  // No result may appear right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // The vblank pulse only comes with vblank mode
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[11] |-> m_tdata[1:0] == MODE_VBLANK)
    else $error("vblank pulse outside vblank mode");

  // Frame-ready falls on a visible line, never with the vblank pulse
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[13] |-> !m_tdata[11] && m_tdata[1:0] != MODE_VBLANK)
    else $error("frame ready in vblank");

  // A result out of an empty buffer needs a tick accepted earlier through the input register
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without accepted tick");

endmodule

bind lcd_scanline_mode_timer lsmt_checker u_lsmt_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
